FILE: rtl/core/bis_pkg.sv
`timescale 1ns / 1ps
package bis_pkg;

  localparam int MAX_SRC_COLS   = 32;
  localparam int MAX_SRC_ROWS   = 32;
  localparam int OUT_COORD_BITS = 10;

  localparam int CFG_BITS    = 6;
  localparam int FCOL_BITS   = 5;
  localparam int FROW_BITS   = 5;
  localparam int SAMPLE_BITS = 24;
  localparam int PIX_BITS    = 16;

  localparam int COL_BITS  = $clog2(MAX_SRC_COLS);
  localparam int ROW_BITS  = $clog2(MAX_SRC_ROWS);
  localparam int DEPTH     = MAX_SRC_COLS * MAX_SRC_ROWS;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int DIM_MAX   = (MAX_SRC_COLS > MAX_SRC_ROWS) ? MAX_SRC_COLS : MAX_SRC_ROWS;
  localparam int DIM_BITS  = $clog2(DIM_MAX + 1);
  localparam int CMP_BITS  = OUT_COORD_BITS + DIM_BITS;

  localparam int CDIV_STAGES = (OUT_COORD_BITS + 1) / 2;
  localparam int CSH_BITS    = OUT_COORD_BITS + CFG_BITS;

  localparam int WGT_BITS  = 2 * CFG_BITS;
  localparam int TERM_BITS = SAMPLE_BITS + WGT_BITS + 1;
  localparam int ACC_BITS  = TERM_BITS + 2;
  localparam int FRAC_BITS = 8;
  localparam int MAG_BITS  = ACC_BITS - FRAC_BITS;
  localparam int QUO_BITS  = PIX_BITS;
  localparam int QDIV_STAGES = QUO_BITS / 2;
  localparam int BLEND_STAGES = 3;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_SCALE      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    logic [CFG_BITS-1:0] s;
  } dims_t;

  typedef struct packed {
    op_t                       op;
    logic [FCOL_BITS-1:0]      src_col;
    logic [FROW_BITS-1:0]      src_row;
    logic [SAMPLE_BITS-1:0]    sample;
    logic [OUT_COORD_BITS-1:0] out_col;
    logic [OUT_COORD_BITS-1:0] out_row;
  } req_t;

  typedef struct packed {
    logic [OUT_COORD_BITS-1:0] rem;
    logic [OUT_COORD_BITS-1:0] quo;
  } cdiv_t;

  typedef struct packed {
    op_t                    op;
    logic [FCOL_BITS-1:0]   src_col;
    logic [FROW_BITS-1:0]   src_row;
    logic [SAMPLE_BITS-1:0] sample;
    cdiv_t                  dx;
    cdiv_t                  dy;
  } cres_t;

  typedef struct packed {
    logic [3:0][SAMPLE_BITS-1:0] p;
    logic [CFG_BITS-1:0]         fx;
    logic [CFG_BITS-1:0]         fy;
  } blend_in_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] rem;
    logic [QUO_BITS-1:0] quo;
    logic [WGT_BITS-1:0] d;
    logic                neg;
  } qdiv_t;

  function automatic cdiv_t cdiv_step(cdiv_t a, logic [CFG_BITS-1:0] s, int i);
    logic [CSH_BITS-1:0] sh;
    cdiv_t r;
    r  = a;
    sh = CSH_BITS'(s) << i;
    if (CSH_BITS'(a.rem) >= sh) begin
      r.rem    = a.rem - sh[OUT_COORD_BITS-1:0];
      r.quo[i] = 1'b1;
    end
    return r;
  endfunction

  // two restoring steps per stage, msb first
  function automatic cdiv_t cdiv_pair(cdiv_t a, logic [CFG_BITS-1:0] s, int k);
    cdiv_t r;
    r = a;
    if (OUT_COORD_BITS - 1 - 2 * k >= 0) r = cdiv_step(r, s, OUT_COORD_BITS - 1 - 2 * k);
    if (OUT_COORD_BITS - 2 - 2 * k >= 0) r = cdiv_step(r, s, OUT_COORD_BITS - 2 - 2 * k);
    return r;
  endfunction

  function automatic qdiv_t qdiv_step(qdiv_t a, int i);
    logic [MAG_BITS-1:0] sh;
    qdiv_t r;
    r  = a;
    sh = MAG_BITS'(a.d) << i;
    if (a.rem >= sh) begin
      r.rem    = a.rem - sh;
      r.quo[i] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] grid_addr(logic [ROW_BITS-1:0] row,
                                                     logic [COL_BITS-1:0] col);
    return ADDR_BITS'(row) * ADDR_BITS'(MAX_SRC_COLS) + ADDR_BITS'(col);
  endfunction

endpackage

FILE: rtl/core/bis_coord_div.sv
`timescale 1ns / 1ps
module bis_coord_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  bis_pkg::req_t                     in_req,
  input  logic [bis_pkg::CFG_BITS-1:0]      scale,
  output logic                              out_valid,
  output bis_pkg::cres_t                    out_res
);

  localparam int STG = bis_pkg::CDIV_STAGES;

  logic [STG-1:0]  vld_r;
  bis_pkg::cres_t  st_r   [STG];
  bis_pkg::cres_t  st_in  [STG];
  bis_pkg::cres_t  st_nxt [STG];

  always_comb begin
    st_in[0].op      = in_req.op;
    st_in[0].src_col = in_req.src_col;
    st_in[0].src_row = in_req.src_row;
    st_in[0].sample  = in_req.sample;
    st_in[0].dx.rem  = in_req.out_col;
    st_in[0].dx.quo  = '0;
    st_in[0].dy.rem  = in_req.out_row;
    st_in[0].dy.quo  = '0;
  end

  for (genvar k = 0; k < STG; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign st_in[k] = st_r[k-1];
    end
    always_comb begin
      st_nxt[k]    = st_in[k];
      st_nxt[k].dx = bis_pkg::cdiv_pair(st_in[k].dx, scale, k);
      st_nxt[k].dy = bis_pkg::cdiv_pair(st_in[k].dy, scale, k);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STG-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[STG-1];
  assign out_res   = st_r[STG-1];

endmodule

FILE: rtl/core/bis_grid.sv
`timescale 1ns / 1ps
module bis_grid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 fe,
  input  bis_pkg::dims_t       dims,
  input  logic                 div_valid,
  input  bis_pkg::cres_t       div_res,
  output logic                 take_ok,
  output logic                 blend_valid,
  output bis_pkg::blend_in_t   blend_data
);

  localparam int CB  = bis_pkg::CMP_BITS;
  localparam int AB  = bis_pkg::ADDR_BITS;
  localparam int SB  = bis_pkg::SAMPLE_BITS;
  localparam int FB  = bis_pkg::CFG_BITS;

  logic [SB-1:0] mem_r [bis_pkg::DEPTH];

  // neighbour indices of the incoming item
  logic [CB-1:0]                 ix, ix1, iy, iy1, wl, hl;
  logic [bis_pkg::COL_BITS-1:0]  x0, x1;
  logic [bis_pkg::ROW_BITS-1:0]  y0, y1;
  logic                          load_ok;

  always_comb begin
    ix  = CB'(div_res.dx.quo);
    iy  = CB'(div_res.dy.quo);
    ix1 = ix + CB'(1);
    iy1 = iy + CB'(1);
    wl  = CB'(dims.w) - CB'(1);
    hl  = CB'(dims.h) - CB'(1);
    x0  = bis_pkg::COL_BITS'((ix  >= CB'(dims.w)) ? wl : ix);
    x1  = bis_pkg::COL_BITS'((ix1 >= CB'(dims.w)) ? wl : ix1);
    y0  = bis_pkg::ROW_BITS'((iy  >= CB'(dims.h)) ? hl : iy);
    y1  = bis_pkg::ROW_BITS'((iy1 >= CB'(dims.h)) ? hl : iy1);
    load_ok = (32'(div_res.src_col) < bis_pkg::MAX_SRC_COLS) &&
              (32'(div_res.src_row) < bis_pkg::MAX_SRC_ROWS);
  end

  // sequencer: one memory access per cycle while the pipeline is not stalled
  logic                   sq_valid_r;
  bis_pkg::op_t           sq_op_r;
  logic                   sq_wok_r;
  logic [AB-1:0]          sq_waddr_r;
  logic [SB-1:0]          sq_wdata_r;
  logic [3:0][AB-1:0]     sq_addr_r;
  logic [FB-1:0]          sq_fx_r, sq_fy_r;
  logic [1:0]             sq_cnt_r;

  logic                   mem_we, mem_re;
  logic [AB-1:0]          raddr;

  assign take_ok = !sq_valid_r || (sq_op_r == bis_pkg::OP_LOAD) || (sq_cnt_r == 2'd3);
  assign mem_we  = en && sq_valid_r && (sq_op_r == bis_pkg::OP_LOAD) && sq_wok_r;
  assign mem_re  = en && sq_valid_r && (sq_op_r == bis_pkg::OP_QUERY);
  assign raddr   = sq_addr_r[sq_cnt_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
      sq_cnt_r   <= 2'd0;
    end else if (fe) begin
      sq_valid_r <= div_valid;
      sq_cnt_r   <= 2'd0;
    end else if (en && sq_valid_r && (sq_op_r == bis_pkg::OP_QUERY)) begin
      sq_cnt_r <= sq_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      sq_op_r      <= div_res.op;
      sq_wok_r     <= load_ok;
      sq_waddr_r   <= bis_pkg::grid_addr(bis_pkg::ROW_BITS'(div_res.src_row),
                                         bis_pkg::COL_BITS'(div_res.src_col));
      sq_wdata_r   <= div_res.sample;
      sq_addr_r[0] <= bis_pkg::grid_addr(y0, x0);
      sq_addr_r[1] <= bis_pkg::grid_addr(y0, x1);
      sq_addr_r[2] <= bis_pkg::grid_addr(y1, x0);
      sq_addr_r[3] <= bis_pkg::grid_addr(y1, x1);
      sq_fx_r      <= FB'(div_res.dx.rem);
      sq_fy_r      <= FB'(div_res.dy.rem);
    end
  end

  // single port source memory
  logic [SB-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[sq_waddr_r] <= sq_wdata_r;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

  // read tracking and neighbour collection
  logic           rvld_r;
  logic [1:0]     ridx_r;
  logic [FB-1:0]  rfx_r, rfy_r;
  logic           coll_valid_r;
  logic [3:0][SB-1:0] p_r;
  logic [FB-1:0]  cfx_r, cfy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r       <= 1'b0;
      coll_valid_r <= 1'b0;
    end else if (en) begin
      rvld_r       <= mem_re;
      coll_valid_r <= rvld_r && (ridx_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ridx_r <= sq_cnt_r;
      rfx_r  <= sq_fx_r;
      rfy_r  <= sq_fy_r;
      cfx_r  <= rfx_r;
      cfy_r  <= rfy_r;
      if (rvld_r) begin
        p_r <= {rd_data_r, p_r[3:1]};
      end
    end
  end

  assign blend_valid   = coll_valid_r;
  assign blend_data.p  = p_r;
  assign blend_data.fx = cfx_r;
  assign blend_data.fy = cfy_r;

endmodule

FILE: rtl/core/bis_blend.sv
`timescale 1ns / 1ps
module bis_blend (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic [bis_pkg::CFG_BITS-1:0]        scale,
  input  logic                                in_valid,
  input  bis_pkg::blend_in_t                  in_data,
  output logic                                out_valid,
  output logic signed [bis_pkg::PIX_BITS-1:0] pixel,
  output logic                                sat
);

  localparam int FB  = bis_pkg::CFG_BITS;
  localparam int WB  = bis_pkg::WGT_BITS;
  localparam int SB  = bis_pkg::SAMPLE_BITS;
  localparam int TB  = bis_pkg::TERM_BITS;
  localparam int ACB = bis_pkg::ACC_BITS;
  localparam int MB  = bis_pkg::MAG_BITS;
  localparam int QS  = bis_pkg::QDIV_STAGES;
  localparam int NS  = bis_pkg::BLEND_STAGES + QS;
  localparam int PB  = bis_pkg::PIX_BITS;

  logic [NS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // weights and divisor
  logic [3:0][WB-1:0] w_r;
  logic [3:0][SB-1:0] p0_r;
  logic [WB-1:0]      d0_r;
  logic [FB-1:0]      wx0, wy0;

  assign wx0 = scale - in_data.fx;
  assign wy0 = scale - in_data.fy;

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= WB'(wx0) * WB'(wy0);
      w_r[1] <= WB'(in_data.fx) * WB'(wy0);
      w_r[2] <= WB'(wx0) * WB'(in_data.fy);
      w_r[3] <= WB'(in_data.fx) * WB'(in_data.fy);
      d0_r   <= WB'(scale) * WB'(scale);
      p0_r   <= in_data.p;
    end
  end

  // weighted terms
  logic signed [TB-1:0] t_r [4];
  logic [WB-1:0]        d1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        t_r[k] <= TB'($signed(p0_r[k]) * $signed({1'b0, w_r[k]}));
      end
      d1_r <= d0_r;
    end
  end

  // sum
  logic signed [ACB-1:0] acc_r;
  logic [WB-1:0]         d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= ACB'(t_r[0]) + ACB'(t_r[1]) + ACB'(t_r[2]) + ACB'(t_r[3]);
      d2_r  <= d1_r;
    end
  end

  // magnitude with the fraction dropped, truncation toward zero
  logic [ACB-1:0]  absacc;
  bis_pkg::qdiv_t  q_in [QS];
  bis_pkg::qdiv_t  q_r  [QS];

  assign absacc = acc_r[ACB-1] ? ACB'(-acc_r) : ACB'(acc_r);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0].rem <= MB'(absacc >> bis_pkg::FRAC_BITS);
      q_r[0].quo <= '0;
      q_r[0].d   <= d2_r;
      q_r[0].neg <= acc_r[ACB-1];
    end
  end

  // restoring divide by scale squared, two quotient bits per stage
  for (genvar k = 1; k < QS; k++) begin : g_qdiv
    always_comb begin
      q_in[k] = bis_pkg::qdiv_step(q_r[k-1], bis_pkg::QUO_BITS - 2 * k + 1);
      q_in[k] = bis_pkg::qdiv_step(q_in[k], bis_pkg::QUO_BITS - 2 * k);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_in[k];
      end
    end
  end

  // last two steps and saturation
  bis_pkg::qdiv_t       qf;
  logic [PB:0]          qmag;

  always_comb begin
    q_in[0] = bis_pkg::qdiv_step(q_r[QS-1], 1);
    qf      = bis_pkg::qdiv_step(q_in[0], 0);
    qmag    = {1'b0, qf.quo};
    if (!qf.neg) begin
      sat   = qmag > (PB+1)'(2 ** (PB - 1) - 1);
      pixel = sat ? PB'(2 ** (PB - 1) - 1) : PB'(qmag);
    end else begin
      sat   = qmag > (PB+1)'(2 ** (PB - 1));
      pixel = sat ? PB'(2 ** (PB - 1)) : PB'(-qmag);
    end
  end

  assign out_valid = vld_r[NS-1];

endmodule

FILE: rtl/core/bilinear_image_upscaler_core.sv
`timescale 1ns / 1ps
// bilinear image upscaler core
// holds a source image of up to 32 x 32 signed Q15.8 samples and answers
// single pixel requests of the image upscaled by an integer ratio
// input channel (in_*): in_tuser 0 is a load, writing in_tdata's sample at
// (src_row, src_col); in_tuser 1 is a query for output pixel (out_row, out_col)
// result channel (out_*): one transfer per query carrying the interpolated
// value, truncated toward zero and clipped to 16 bits; out_tuser flags clipping
// configuration: cfg_wr_en with cfg_index / cfg_wdata writes src_width,
// src_height or scale_factor; write only while the core is idle
// a query makes four neighbour reads on the single port source memory, a
// load one write on the same port; inputs wait for a query's last read
// path from input transfer to result transfer: 5 divider stages,
// sequencer, 4 reads, collection, 11 blend and divide stages, output register
// reset: registers go to 32 x 24 with scale 10; the source image is undefined
// until loaded, so every sample a query touches must be loaded first
// stall: while a result waits with out_tready low the whole pipeline holds and
// in_tready is low; in_tready is also low until a query's last read is issued
module bilinear_image_upscaler_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // src_col[4:0] src_row[9:5] sample[33:10]
                                  // out_col[43:34] out_row[53:44], zero pad
  input  logic        in_tuser,   // operation
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pixel_value[15:0]
  output logic        out_tuser   // saturated
);

  localparam int DB = bis_pkg::DIM_BITS;
  localparam int FB = bis_pkg::CFG_BITS;

  // configuration registers
  logic [FB-1:0] src_width_r, src_height_r, scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= FB'(32);
      src_height_r <= FB'(24);
      scale_r      <= FB'(10);
    end else if (cfg_wr_en) begin
      case (bis_pkg::cfg_idx_t'(cfg_index))
        bis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        bis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        bis_pkg::CFG_SCALE:      scale_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize clamps to storage
  bis_pkg::dims_t dims;

  always_comb begin
    if (src_width_r == '0)
      dims.w = DB'(1);
    else if (32'(src_width_r) > bis_pkg::MAX_SRC_COLS)
      dims.w = DB'(bis_pkg::MAX_SRC_COLS);
    else
      dims.w = DB'(src_width_r);
    if (src_height_r == '0)
      dims.h = DB'(1);
    else if (32'(src_height_r) > bis_pkg::MAX_SRC_ROWS)
      dims.h = DB'(bis_pkg::MAX_SRC_ROWS);
    else
      dims.h = DB'(src_height_r);
    dims.s = (scale_r == '0) ? FB'(1) : scale_r;
  end

  // input unpacking
  bis_pkg::req_t req;

  always_comb begin
    req.op      = bis_pkg::op_t'(in_tuser);
    req.src_col = in_tdata[4:0];
    req.src_row = in_tdata[9:5];
    req.sample  = in_tdata[33:10];
    req.out_col = in_tdata[43:34];
    req.out_row = in_tdata[53:44];
  end

  // pipeline enables: en gates every stage, fe also needs the sequencer free
  logic out_valid_r;
  logic en, fe, take_ok;

  assign en        = !out_valid_r || out_tready;
  assign fe        = en && take_ok;
  assign in_tready = fe;

  logic           div_valid;
  bis_pkg::cres_t div_res;

  bis_coord_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (fe),
    .in_valid  (in_tvalid),
    .in_req    (req),
    .scale     (dims.s),
    .out_valid (div_valid),
    .out_res   (div_res)
  );

  logic               bl_in_valid;
  bis_pkg::blend_in_t bl_in;

  bis_grid u_grid (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .fe          (fe),
    .dims        (dims),
    .div_valid   (div_valid),
    .div_res     (div_res),
    .take_ok     (take_ok),
    .blend_valid (bl_in_valid),
    .blend_data  (bl_in)
  );

  logic                bl_valid;
  logic signed [15:0]  bl_pixel;
  logic                bl_sat;

  bis_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .scale     (dims.s),
    .in_valid  (bl_in_valid),
    .in_data   (bl_in),
    .out_valid (bl_valid),
    .pixel     (bl_pixel),
    .sat       (bl_sat)
  );

  // output register
  logic [15:0] out_pix_r;
  logic        out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= bl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r <= bl_pixel;
      out_sat_r <= bl_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_sat_r;

endmodule

FILE: sim/bilinear_image_upscaler_core_tb.sv
`timescale 1ns / 1ps
module bilinear_image_upscaler_core_tb;
  import bis_pkg::*;

  // pixel request as queued for the driver
  typedef struct {
    op_t                       op;
    logic [4:0]                src_col;
    logic [4:0]                src_row;
    logic signed [23:0]        sample;
    logic [9:0]                out_col;
    logic [9:0]                out_row;
  } pix_req_t;

  // interpolated pixel as the result channel carries it
  typedef struct {
    logic signed [15:0] value;
    logic               clipped;
  } pix_res_t;

  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  bilinear_image_upscaler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow of the core state used for prediction
  logic signed [23:0] shadow_grid [0:DEPTH-1];
  logic [5:0]         cur_width;
  logic [5:0]         cur_height;
  logic [5:0]         cur_scale;

  pix_req_t pending_reqs[$];
  pix_res_t expected_pixels[$];

  int  error_count;
  int  idle_cycles;
  bit  long_holdoff;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // bilinear blend with exact integer weights, truncation toward zero and clipping
  function automatic pix_res_t interpolate_pixel(pix_req_t r);
    int unsigned w, h, s, ix, iy, fx, fy, x0, x1, y0, y1;
    longint acc, q;
    pix_res_t res;
    w = (cur_width == 0) ? 1 : ((cur_width > MAX_SRC_COLS) ? MAX_SRC_COLS : cur_width);
    h = (cur_height == 0) ? 1 : ((cur_height > MAX_SRC_ROWS) ? MAX_SRC_ROWS : cur_height);
    s = (cur_scale == 0) ? 1 : cur_scale;
    ix = r.out_col / s;
    fx = r.out_col % s;
    iy = r.out_row / s;
    fy = r.out_row % s;
    x0 = (ix >= w) ? w - 1 : ix;
    x1 = (ix + 1 >= w) ? w - 1 : ix + 1;
    y0 = (iy >= h) ? h - 1 : iy;
    y1 = (iy + 1 >= h) ? h - 1 : iy + 1;
    acc = longint'(shadow_grid[y0 * MAX_SRC_COLS + x0]) * longint'(s - fx) * longint'(s - fy)
        + longint'(shadow_grid[y0 * MAX_SRC_COLS + x1]) * longint'(fx) * longint'(s - fy)
        + longint'(shadow_grid[y1 * MAX_SRC_COLS + x0]) * longint'(s - fx) * longint'(fy)
        + longint'(shadow_grid[y1 * MAX_SRC_COLS + x1]) * longint'(fx) * longint'(fy);
    q = acc / longint'(s * s * 256);
    res.clipped = 1'b0;
    if (q > 32767) begin
      q = 32767;
      res.clipped = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      res.clipped = 1'b1;
    end
    res.value = q[15:0];
    return res;
  endfunction

  // loads touch the shadow grid, queries leave one expected pixel
  function automatic void apply_request(pix_req_t r);
    if (r.op == OP_LOAD) begin
      shadow_grid[r.src_row * MAX_SRC_COLS + r.src_col] = r.sample;
    end else begin
      expected_pixels.push_back(interpolate_pixel(r));
    end
  endfunction

  // queue one load, unused query fields random
  function automatic void queue_load(int row, int col, logic signed [23:0] v);
    pix_req_t r;
    r.op = OP_LOAD;
    r.src_col = col[4:0];
    r.src_row = row[4:0];
    r.sample = v;
    r.out_col = 10'($urandom);
    r.out_row = 10'($urandom);
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_query(int oc, int orow);
    pix_req_t r;
    r.op = OP_QUERY;
    r.src_col = 5'($urandom);
    r.src_row = 5'($urandom);
    r.sample = 24'($urandom);
    r.out_col = oc[9:0];
    r.out_row = orow[9:0];
    pending_reqs.push_back(r);
  endfunction

  // sampled ready of the last rising edge, for the driver
  logic in_tready_s;
  always @(posedge clk) in_tready_s <= in_tready;

  // driver: bursts of random length, random gaps, optional pause for drain
  int  burst_left;
  int  gap_left;
  bit  pause_for_drain;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready_s) begin
        // transfer taken at the last rising edge
        if (burst_left > 0) burst_left--;
      end
      if (in_tvalid && !in_tready_s) begin
        // hold the offered item
      end else if (pending_reqs.size() == 0 || pause_for_drain) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
        if (gap_left > 0) begin
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].op;
          in_tdata  <= {2'b00, pending_reqs[0].out_row, pending_reqs[0].out_col,
                        pending_reqs[0].sample, pending_reqs[0].src_row,
                        pending_reqs[0].src_col};
          pending_reqs.pop_front();
        end
      end
    end
  end

  // accepted inputs are predicted at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pix_req_t r;
      r.op      = op_t'(in_tuser);
      r.src_col = in_tdata[4:0];
      r.src_row = in_tdata[9:5];
      r.sample  = in_tdata[33:10];
      r.out_col = in_tdata[43:34];
      r.out_row = in_tdata[53:44];
      apply_request(r);
    end
  end

  // receiver stall pattern, with one long hold-off counted here
  int stall_phase;
  int holdoff_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_holdoff && holdoff_left == 0) begin
      holdoff_left = 400;
      long_holdoff = 1'b0;
      out_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 200;
      if (stall_phase < 60) out_tready <= 1'b1;
      else if (stall_phase < 130) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 2) == 0);
    end
  end

  // monitor: compare each result transfer with the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d clipped %0b",
                 $time, $signed(out_tdata), out_tuser);
        error_count++;
      end else begin
        pix_res_t e;
        e = expected_pixels.pop_front();
        if (out_tdata !== e.value) begin
          $display("%0t: pixel value mismatch, expected %0d, actual %0d",
                   $time, e.value, $signed(out_tdata));
          error_count++;
        end
        if (out_tuser !== e.clipped) begin
          $display("%0t: clip flag mismatch, expected %0b, actual %0b",
                   $time, e.clipped, out_tuser);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("bilinear_image_upscaler_core_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [5:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  cur_width = v;
      CFG_SRC_HEIGHT: cur_height = v;
      default:        cur_scale = v;
    endcase
  endtask

  // wait until everything queued is sent and answered, then let loads settle
  task automatic drain_all();
    while (pending_reqs.size() != 0 || in_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // load the 16 x 16 corner block plus the whole first row and first column,
  // some samples at the extremes
  task automatic load_grid();
    for (int r = 0; r < MAX_SRC_ROWS; r++)
      for (int c = 0; c < MAX_SRC_COLS; c++) begin
        if ((r < 16 && c < 16) || r == 0 || c == 0) begin
          case ($urandom_range(0, 7))
            0: queue_load(r, c, 24'sh7FFFFF);
            1: queue_load(r, c, -24'sh800000);
            2: queue_load(r, c, 24'(int'($urandom_range(0, 4000)) - 2000));
            default: queue_load(r, c, 24'($urandom));
          endcase
        end
      end
  endtask

  // random phase: queries mixed with overwriting loads
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        queue_load($urandom_range(0, 31), $urandom_range(0, 31), 24'($urandom));
      else if ($urandom_range(0, 5) == 0)
        queue_query($urandom_range(0, 1023), $urandom_range(0, 1023));
      else begin
        int sc;
        sc = (cur_scale == 0) ? 1 : cur_scale;
        queue_query($urandom_range(0, sc * 33 > 1023 ? 1023 : sc * 33),
                    $urandom_range(0, sc * 33 > 1023 ? 1023 : sc * 33));
      end
    end
  endtask

  initial begin
    error_count = 0;
    long_holdoff = 1'b0;
    pause_for_drain = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    holdoff_left = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SRC_WIDTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_LOAD;
    out_tready = 1'b0;
    cur_width = 6'd32;
    cur_height = 6'd24;
    cur_scale = 6'd10;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_grid[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset register values, queries in and just past the loaded block
    pause_for_drain = 1'b1;
    load_grid();
    pause_for_drain = 1'b0;
    drain_all();
    queue_query(0, 0);
    queue_query(5, 5);
    queue_query(9, 9);
    queue_query(149, 149);
    queue_query(140, 3);
    queue_query(3, 150);
    drain_all();

    // edges and far coordinates on a 16 x 16 source
    write_reg(CFG_SRC_WIDTH, 6'd16);
    write_reg(CFG_SRC_HEIGHT, 6'd16);
    queue_query(1023, 1023);
    queue_query(1023, 0);
    queue_query(0, 1023);
    queue_query(159, 159);
    queue_query(155, 20);
    queue_query(310, 0);
    drain_all();

    // extreme register values including zero and oversize, scale one, zero and 63
    write_reg(CFG_SCALE, 6'd1);
    write_reg(CFG_SRC_WIDTH, 6'd0);
    write_reg(CFG_SRC_HEIGHT, 6'd63);
    queue_query(0, 0);
    queue_query(31, 31);
    queue_query(1023, 500);
    drain_all();
    write_reg(CFG_SCALE, 6'd0);
    write_reg(CFG_SRC_WIDTH, 6'd33);
    write_reg(CFG_SRC_HEIGHT, 6'd0);
    queue_query(40, 3);
    queue_query(7, 1023);
    drain_all();
    write_reg(CFG_SCALE, 6'd63);
    write_reg(CFG_SRC_WIDTH, 6'd1);
    write_reg(CFG_SRC_HEIGHT, 6'd1);
    queue_query(62, 62);
    queue_query(1000, 31);
    drain_all();

    // long receiver hold-off while the sender keeps offering
    write_reg(CFG_SRC_WIDTH, 6'd16);
    write_reg(CFG_SRC_HEIGHT, 6'd16);
    write_reg(CFG_SCALE, 6'd32);
    long_holdoff = 1'b1;
    random_phase(100);
    drain_all();

    // several register settings, random traffic in each
    write_reg(CFG_SCALE, 6'd3);
    write_reg(CFG_SRC_WIDTH, 6'd16);
    write_reg(CFG_SRC_HEIGHT, 6'd9);
    random_phase(100);
    drain_all();
    write_reg(CFG_SCALE, 6'd10);
    write_reg(CFG_SRC_WIDTH, 6'd16);
    write_reg(CFG_SRC_HEIGHT, 6'd16);
    random_phase(100);
    drain_all();
    write_reg(CFG_SCALE, 6'd7);
    write_reg(CFG_SRC_WIDTH, 6'd2);
    write_reg(CFG_SRC_HEIGHT, 6'd16);
    random_phase(100);
    drain_all();
    write_reg(CFG_SCALE, 6'd1);
    write_reg(CFG_SRC_WIDTH, 6'd16);
    write_reg(CFG_SRC_HEIGHT, 6'd16);
    random_phase(100);
    drain_all();
    write_reg(CFG_SCALE, 6'd32);
    write_reg(CFG_SRC_WIDTH, 6'd63);
    write_reg(CFG_SRC_HEIGHT, 6'd1);
    random_phase(50);
    drain_all();

    if (error_count == 0) begin
      $display("bilinear_image_upscaler_core_tb: done, clean");
    end else begin
      $display("bilinear_image_upscaler_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: bilinear_image_upscaler_core.f
rtl/core/bis_pkg.sv
rtl/core/bis_coord_div.sv
rtl/core/bis_grid.sv
rtl/core/bis_blend.sv
rtl/core/bilinear_image_upscaler_core.sv
sim/bilinear_image_upscaler_core_tb.sv
